>>> src/particle_euler_step_speed_limit_macros.svh
// Assertion helpers shared by the RTL files of the particle integrator.
`ifndef PARTICLE_EULER_STEP_SPEED_LIMIT_MACROS_SVH
`define PARTICLE_EULER_STEP_SPEED_LIMIT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off while reset is held.
`define PESL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define PESL_ASSERT_IMP(lbl, ante, cons, msg) \
  `PESL_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> src/pesl_pkg.sv
package pesl_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned LIMIT_INT  = 5;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned LIMIT_W    = 31;
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned RD_STEPS   = DATA_W;
  localparam int unsigned RD_CNT_W   = $clog2(RD_STEPS);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64'(LIMIT_INT) << FRAC_BITS);

  // Input item kinds.
  localparam logic [1:0] MODE_FORCE   = 2'd0;
  localparam logic [1:0] MODE_STEP    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_START_POS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_POS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_VEL_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_VEL_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd4;

  // Request to the shared root / divide unit.
  typedef struct packed {
    logic start;
    logic op_div;   // 1: divide, 0: square root
  } rd_req_t;

  // Signed add that clamps to the 32-bit range.
  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

>>> src/pesl_mul.sv
module pesl_mul
  import pesl_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output logic [PROD_W-1:0] p_o
);

  logic [PROD_W-1:0] p_q;

  // Unsigned product, registered; it holds while en_i is low.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

>>> src/pesl_root_div.sv
`include "particle_euler_step_speed_limit_macros.svh"

module pesl_root_div
  import pesl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rd_req_t           req_i,
  input  logic [PROD_W-1:0] a_i,     // radicand or dividend
  input  logic [DATA_W-1:0] b_i,     // divisor
  output logic              done_o,
  output logic [DATA_W-1:0] res_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [RD_CNT_W-1:0] cnt_q, cnt_d;
  logic                op_div_q;
  logic [PROD_W-1:0]   x_q;
  logic [DATA_W:0]     rem_q;
  logic [DATA_W-1:0]   res_q;
  logic [DATA_W-1:0]   dvs_q;

  logic [DATA_W+2:0]   rs;
  logic [DATA_W+2:0]   trial;
  logic [DATA_W+3:0]   diff;
  logic                ge;

  // One restoring step: the same subtractor serves both operations.
  always_comb begin
    if (op_div_q) begin
      rs    = {2'b00, rem_q[DATA_W-1:0], x_q[PROD_W-1]};
      trial = {3'b000, dvs_q};
    end else begin
      rs    = {rem_q, x_q[PROD_W-1 -: 2]};
      trial = {1'b0, res_q, 2'b01};
    end
    diff = {1'b0, rs} - {1'b0, trial};
    ge   = !diff[DATA_W+3];
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == RD_CNT_W'(RD_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_div_q <= req_i.op_div;
      dvs_q    <= b_i;
      res_q    <= '0;
      if (req_i.op_div) begin
        x_q   <= {a_i[DATA_W-1:0], {DATA_W{1'b0}}};
        rem_q <= {1'b0, a_i[PROD_W-1:DATA_W]};
      end else begin
        x_q   <= a_i;
        rem_q <= '0;
      end
    end else if (busy_q) begin
      res_q <= {res_q[DATA_W-2:0], ge};
      rem_q <= ge ? diff[DATA_W:0] : rs[DATA_W:0];
      x_q   <= op_div_q ? {x_q[PROD_W-2:0], 1'b0} : {x_q[PROD_W-3:0], 2'b00};
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `PESL_ASSERT(rd_no_start_busy, !(req_i.start && busy_q), "start while a run is in progress")
  `PESL_ASSERT_IMP(rd_done_after_run, done_q, $past(busy_q) && !busy_q, "done without a run")

endmodule

>>> src/particle_euler_step_speed_limit.sv
// Two-dimensional point-mass integrator, signed Q16.16, with a speed limit.
// Input items arrive on the s_axis channel: tuser carries the mode (add force,
// step, restart, or an unused code that changes nothing) and tdata the force.
// Every item gives exactly one result item on m_axis: position, velocity and,
// in tuser, whether this item scaled the velocity down to the speed limit.
// The start state and the speed limit are set through the cfg write port.
// The user must write them only while the block is idle; it does not enforce it.
// The block works on one item at a time and drops s_axis_tready until it is
// done. A force, restart or unused item goes to the result register directly.
// A step forms the speed squared and the limit squared with the multiplier and
// compares them; if the speed is over the limit, one shared 32-bit restoring
// unit first takes the square root of the speed squared and then divides each
// velocity component, one result bit per cycle. The position is updated last.
// A new item can be accepted in the cycle after the result register is loaded.
// Results sit in an output register, so the next item is taken while one
// result waits; if the receiver stalls, the following result waits in the
// sequencer and no further item is accepted until the register is free.
// Reset clears the particle and start state to zero and the speed limit to 5.0.
`include "particle_euler_step_speed_limit_macros.svh"

module particle_euler_step_speed_limit
  import pesl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input items.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,   // force_x [31:0], force_y [63:32]
  input  logic [1:0]           s_axis_tuser,   // mode [1:0]
  // Result items.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [127:0]         m_axis_tdata,   // pos_x, pos_y, vel_x, vel_y from bit 0 up
  output logic                 m_axis_tuser,   // speed_clamped
  // Configuration writes.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL_X  = 4'd1;
  localparam logic [3:0] ST_MUL_Y  = 4'd2;
  localparam logic [3:0] ST_MUL_L  = 4'd3;
  localparam logic [3:0] ST_CMP    = 4'd4;
  localparam logic [3:0] ST_SQRT   = 4'd5;
  localparam logic [3:0] ST_DIVX_M = 4'd6;
  localparam logic [3:0] ST_DIVX   = 4'd7;
  localparam logic [3:0] ST_DIVY   = 4'd8;
  localparam logic [3:0] ST_POS    = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  logic [3:0]         state_q, state_d;

  // Configuration registers.
  logic [DATA_W-1:0]  spos_x_q, spos_y_q, svel_x_q, svel_y_q;
  logic [LIMIT_W-1:0] lim_q;

  // Particle state.
  logic [DATA_W-1:0]  acc_x_q, acc_y_q, vel_x_q, vel_y_q, pos_x_q, pos_y_q;
  logic               clamped_q;

  // Working registers of a step.
  logic [PROD_W-1:0]  s_q;
  logic [DATA_W-1:0]  mag_q;

  // Output register.
  logic               out_valid_q;
  logic [127:0]       out_data_q;
  logic               out_clamp_q;

  logic               accept;
  logic               out_free;
  logic [DATA_W-1:0]  vx_abs, vy_abs, lim_ext;

  logic               mul_en;
  logic [DATA_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0]  mul_p;

  rd_req_t            rd_req;
  logic [PROD_W-1:0]  rd_a;
  logic               rd_done;
  logic [DATA_W-1:0]  rd_res;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  assign vx_abs  = vel_x_q[DATA_W-1] ? DATA_W'(-vel_x_q) : vel_x_q;
  assign vy_abs  = vel_y_q[DATA_W-1] ? DATA_W'(-vel_y_q) : vel_y_q;
  assign lim_ext = {1'b0, lim_q};

  // Next state, and the requests to the multiplier and the root/divide unit.
  always_comb begin
    state_d       = state_q;
    mul_en        = 1'b0;
    mul_a         = vx_abs;
    mul_b         = vx_abs;
    rd_req.start  = 1'b0;
    rd_req.op_div = 1'b1;
    rd_a          = mul_p;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (s_axis_tuser == MODE_STEP) ? ST_MUL_X : ST_DONE;
        end
      end
      ST_MUL_X: begin
        mul_en  = 1'b1;
        state_d = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        mul_en  = 1'b1;
        mul_a   = vy_abs;
        mul_b   = vy_abs;
        state_d = ST_MUL_L;
      end
      ST_MUL_L: begin
        mul_en  = 1'b1;
        mul_a   = lim_ext;
        mul_b   = lim_ext;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        // The product register now holds the limit squared.
        if (s_q > mul_p) begin
          rd_req.start  = 1'b1;
          rd_req.op_div = 1'b0;
          rd_a          = s_q;
          state_d       = ST_SQRT;
        end else begin
          state_d = ST_POS;
        end
      end
      ST_SQRT: begin
        if (rd_done) begin
          mul_en  = 1'b1;
          mul_b   = lim_ext;
          state_d = ST_DIVX_M;
        end
      end
      ST_DIVX_M: begin
        rd_req.start = 1'b1;
        mul_en       = 1'b1;
        mul_a        = vy_abs;
        mul_b        = lim_ext;
        state_d      = ST_DIVX;
      end
      ST_DIVX: begin
        if (rd_done) begin
          rd_req.start = 1'b1;
          state_d      = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (rd_done) begin
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spos_x_q <= '0;
      spos_y_q <= '0;
      svel_x_q <= '0;
      svel_y_q <= '0;
      lim_q    <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_POS_X: spos_x_q <= cfg_data_i;
        REG_START_POS_Y: spos_y_q <= cfg_data_i;
        REG_START_VEL_X: svel_x_q <= cfg_data_i;
        REG_START_VEL_Y: svel_y_q <= cfg_data_i;
        REG_SPEED_LIMIT: lim_q    <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Particle state. Each velocity component is scaled by limit / length with
  // a truncating divide of magnitudes; the original sign is put back after.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q   <= '0;
      acc_y_q   <= '0;
      vel_x_q   <= '0;
      vel_y_q   <= '0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      clamped_q <= 1'b0;
    end else begin
      if (accept) begin
        clamped_q <= 1'b0;
        unique case (s_axis_tuser)
          MODE_FORCE: begin
            acc_x_q <= sat_add(acc_x_q, s_axis_tdata[31:0]);
            acc_y_q <= sat_add(acc_y_q, s_axis_tdata[63:32]);
          end
          MODE_STEP: begin
            vel_x_q <= sat_add(vel_x_q, acc_x_q);
            vel_y_q <= sat_add(vel_y_q, acc_y_q);
            acc_x_q <= '0;
            acc_y_q <= '0;
          end
          MODE_RESTART: begin
            pos_x_q <= spos_x_q;
            pos_y_q <= spos_y_q;
            vel_x_q <= svel_x_q;
            vel_y_q <= svel_y_q;
            acc_x_q <= '0;
            acc_y_q <= '0;
          end
          MODE_NONE: ;
        endcase
      end
      if (state_q == ST_DIVX && rd_done) begin
        vel_x_q <= vel_x_q[DATA_W-1] ? DATA_W'(-rd_res) : rd_res;
      end
      if (state_q == ST_DIVY && rd_done) begin
        vel_y_q   <= vel_y_q[DATA_W-1] ? DATA_W'(-rd_res) : rd_res;
        clamped_q <= 1'b1;
      end
      if (state_q == ST_POS) begin
        pos_x_q <= sat_add(pos_x_q, vel_x_q);
        pos_y_q <= sat_add(pos_y_q, vel_y_q);
      end
    end
  end

  // Speed squared is built from the two squares; the length is kept for the
  // two divides.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL_Y) begin
      s_q <= mul_p;
    end else if (state_q == ST_MUL_L) begin
      s_q <= s_q + mul_p;
    end
    if (state_q == ST_SQRT && rd_done) begin
      mag_q <= rd_res;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_data_q  <= {vel_y_q, vel_x_q, pos_y_q, pos_x_q};
      out_clamp_q <= clamped_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_clamp_q;

  pesl_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  pesl_root_div u_root_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rd_req),
    .a_i    (rd_a),
    .b_i    (mag_q),
    .done_o (rd_done),
    .res_o  (rd_res)
  );

  `PESL_ASSERT_IMP(top_mag_nonzero, state_q == ST_DIVX_M, mag_q != '0, "zero length before divide")
  `PESL_ASSERT_IMP(top_clamp_in_limit, state_q == ST_POS && clamped_q, vx_abs <= lim_ext && vy_abs <= lim_ext, "clamped component above limit")

endmodule

>>> tb/sv/particle_euler_step_speed_limit_tb.sv
// Testbench for the particle integrator with a speed limit.
//
// A directed table comes first. Some rows are register writes. The others are
// items, and a few of those carry a result typed in by hand where it is obvious:
// after reset, at the extremes, and at the exact-limit step. Random phases
// follow. Each phase reprograms every register while the block is idle and then
// streams mostly well-formed force/step sequences, with some restarts and some
// unused-mode noise.
//
// An internal model of the particle tracks acceleration, velocity, position and
// the start/limit registers. It produces the expected result of every accepted
// item. Results are matched in order against a queue of expectations.
module particle_euler_step_speed_limit_tb
  import pesl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_PHASES      = 9;
  localparam int unsigned ITEMS_PER_PHASE = 55;
  localparam int unsigned MAX_IDLE        = 19;
  // A clamped step is the slowest item.
  localparam int unsigned DRAIN_CYCLES    = 120;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam realtime     RUN_LIMIT       = 5ms;

  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [31:0] Q_ZERO = 32'h0000_0000;

  localparam longint SUM_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SUM_LO = 64'shFFFF_FFFF_8000_0000;

  // One result item as the block reports it.
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic        clamped;
  } motion_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [31:0]            data;
    logic [1:0]             mode;
    logic [31:0]            force_x;
    logic [31:0]            force_y;
    logic                   typed;
    motion_t                want;
  } row_t;

  localparam int unsigned NUM_ROWS = 26;

  // Directed rows. A typed row checks against the hand-written result.
  // Every other row is checked against the particle model.
  localparam row_t DIRECTED [NUM_ROWS] = '{
    // A step right after reset leaves everything at zero.
    '{ROW_ITEM, REG_START_POS_X, Q_ZERO, MODE_STEP, Q_ZERO, Q_ZERO,
      1'b1, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0}},
    // The unused mode changes nothing, whatever the force says.
    '{ROW_ITEM, REG_START_POS_X, Q_ZERO, MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      1'b1, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0}},
    // Two extreme forces: the acceleration sums saturate, and position and
    // velocity are unaffected.
    '{ROW_ITEM, REG_START_POS_X, Q_ZERO, MODE_FORCE, Q_MAX, Q_MIN,
      1'b1, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0}},
    '{ROW_ITEM, REG_START_POS_X, Q_ZERO, MODE_FORCE, Q_MAX, Q_MIN,
      1'b1, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0}},
    // A huge vector against the default limit of 5.0.
    '{ROW_ITEM, REG_START_POS_X, Q_ZERO, MODE_STEP, Q_ZERO, Q_ZERO, 1'b0, '0},
    '{ROW_CFG, REG_SPEED_LIMIT, Q_MAX, MODE_NONE, Q_ZERO, Q_ZERO, 1'b0, '0},
    '{ROW_CFG, REG_START_POS_X, 32'h7FFF_FFF0, MODE_NONE, Q_ZERO, Q_ZERO, 1'b0, '0},
    '{ROW_CFG, REG_START_POS_Y, 32'h8000_0010, MODE_NONE, Q_ZERO, Q_ZERO, 1'b0, '0},
    '{ROW_CFG, REG_START_VEL_X, Q_MAX, MODE_NONE, Q_ZERO, Q_ZERO, 1'b0, '0},
    '{ROW_CFG, REG_START_VEL_Y, Q_MIN, MODE_NONE, Q_ZERO, Q_ZERO, 1'b0, '0},
    // A restart ignores the force and loads the start registers.
    '{ROW_ITEM, REG_START_POS_X, Q_ZERO, MODE_RESTART, 32'h1234_5678, 32'hEDCB_A987,
      1'b1, '{32'h7FFF_FFF0, 32'h8000_0010, Q_MAX, Q_MIN, 1'b0}},
    // The largest vector still exceeds the largest limit. The positions saturate.
    '{ROW_ITEM, REG_START_POS_X, Q_ZERO, MODE_STEP, Q_ZERO, Q_ZERO, 1'b0, '0},
    '{ROW_CFG, REG_SPEED_LIMIT, Q_ZERO, MODE_NONE, Q_ZERO, Q_ZERO, 1'b0, '0},
    '{ROW_ITEM, REG_START_POS_X, Q_ZERO, MODE_RESTART, Q_ZERO, Q_ZERO,
      1'b1, '{32'h7FFF_FFF0, 32'h8000_0010, Q_MAX, Q_MIN, 1'b0}},
    // With a zero limit any motion is scaled to nothing.
    '{ROW_ITEM, REG_START_POS_X, Q_ZERO, MODE_STEP, Q_ZERO, Q_ZERO,
      1'b1, '{32'h7FFF_FFF0, 32'h8000_0010, Q_ZERO, Q_ZERO, 1'b1}},
    // Zero speed against a zero limit does not count as exceeding it.
    '{ROW_ITEM, REG_START_POS_X, Q_ZERO, MODE_STEP, Q_ZERO, Q_ZERO,
      1'b1, '{32'h7FFF_FFF0, 32'h8000_0010, Q_ZERO, Q_ZERO, 1'b0}},
    '{ROW_CFG, REG_START_POS_X, Q_ZERO, MODE_NONE, Q_ZERO, Q_ZERO, 1'b0, '0},
    '{ROW_CFG, REG_START_POS_Y, Q_ZERO, MODE_NONE, Q_ZERO, Q_ZERO, 1'b0, '0},
    '{ROW_CFG, REG_START_VEL_X, 32'h0003_0000, MODE_NONE, Q_ZERO, Q_ZERO, 1'b0, '0},
    '{ROW_CFG, REG_START_VEL_Y, 32'hFFFC_0000, MODE_NONE, Q_ZERO, Q_ZERO, 1'b0, '0},
    '{ROW_CFG, REG_SPEED_LIMIT, 32'h0005_0000, MODE_NONE, Q_ZERO, Q_ZERO, 1'b0, '0},
    '{ROW_ITEM, REG_START_POS_X, Q_ZERO, MODE_RESTART, Q_ZERO, Q_ZERO,
      1'b1, '{Q_ZERO, Q_ZERO, 32'h0003_0000, 32'hFFFC_0000, 1'b0}},
    // A speed of (3, -4) is exactly 5.0, which is on the limit but not over it.
    '{ROW_ITEM, REG_START_POS_X, Q_ZERO, MODE_STEP, Q_ZERO, Q_ZERO,
      1'b1, '{32'h0003_0000, 32'hFFFC_0000, 32'h0003_0000, 32'hFFFC_0000, 1'b0}},
    '{ROW_ITEM, REG_START_POS_X, Q_ZERO, MODE_FORCE, 32'h0000_0001, Q_ZERO,
      1'b1, '{32'h0003_0000, 32'hFFFC_0000, 32'h0003_0000, 32'hFFFC_0000, 1'b0}},
    // One LSB over the limit forces a clamp.
    '{ROW_ITEM, REG_START_POS_X, Q_ZERO, MODE_STEP, Q_ZERO, Q_ZERO, 1'b0, '0},
    '{ROW_ITEM, REG_START_POS_X, Q_ZERO, MODE_NONE, 32'hA5A5_5A5A, 32'h5A5A_A5A5,
      1'b0, '0}
  };

  logic           clk_i;
  logic           rst_ni;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [63:0]    s_axis_tdata;   // force_x [31:0], force_y [63:32]
  logic [1:0]     s_axis_tuser;   // mode [1:0]
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  logic [127:0]   m_axis_tdata;   // pos_x, pos_y, vel_x, vel_y from bit 0 up
  logic           m_axis_tuser;   // speed_clamped
  logic           cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  particle_euler_step_speed_limit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  // Particle model state and its copy of the registers.
  logic signed [31:0] acc_x, acc_y, vel_x, vel_y, pos_x, pos_y;
  logic signed [31:0] home_px, home_py, home_vx, home_vy;
  logic [30:0]        limit;

  motion_t     expected_motion[$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned steps_sent;
  int unsigned clamps_seen;
  int unsigned cfg_writes;
  bit          no_idle;

  // Signed add that sticks at the ends of the 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > SUM_HI) return Q_MAX;
    if (s < SUM_LO) return Q_MIN;
    return s[31:0];
  endfunction

  function automatic longint unsigned magnitude(input logic signed [31:0] v);
    longint w;
    w = longint'(v);
    return (w < 0) ? longint'(-w) : longint'(w);
  endfunction

  // Floor of the square root, built one bit at a time from the top.
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      b = r | (64'd1 << i);
      if (b * b <= n) r = b;
    end
    return r;
  endfunction

  // Scale one component by limit / length. The quotient truncates toward zero.
  function automatic logic signed [31:0] shrink(input logic signed [31:0] v,
                                                input longint unsigned len);
    longint unsigned q;
    q = (magnitude(v) * longint'(limit)) / len;
    return (v < 0) ? -q[31:0] : q[31:0];
  endfunction

  // Apply one item to the particle and return what the block should report.
  function automatic motion_t advance_particle(input logic [1:0] mode,
                                               input logic signed [31:0] fx,
                                               input logic signed [31:0] fy);
    motion_t         r;
    longint unsigned speed_sq;
    longint unsigned len;
    r.clamped = 1'b0;
    case (mode)
      MODE_FORCE: begin
        acc_x = sat32(acc_x, fx);
        acc_y = sat32(acc_y, fy);
      end
      MODE_STEP: begin
        vel_x = sat32(vel_x, acc_x);
        vel_y = sat32(vel_y, acc_y);
        speed_sq = magnitude(vel_x) * magnitude(vel_x) + magnitude(vel_y) * magnitude(vel_y);
        if (speed_sq > longint'(limit) * longint'(limit)) begin
          len = root_floor(speed_sq);
          if (len == 0) len = 1;
          vel_x = shrink(vel_x, len);
          vel_y = shrink(vel_y, len);
          r.clamped = 1'b1;
        end
        pos_x = sat32(pos_x, vel_x);
        pos_y = sat32(pos_y, vel_y);
        acc_x = '0;
        acc_y = '0;
      end
      MODE_RESTART: begin
        pos_x = home_px;
        pos_y = home_py;
        vel_x = home_vx;
        vel_y = home_vy;
        acc_x = '0;
        acc_y = '0;
      end
      default: ;
    endcase
    r.pos_x = pos_x;
    r.pos_y = pos_y;
    r.vel_x = vel_x;
    r.vel_y = vel_y;
    return r;
  endfunction

  // Mostly small forces of a few units, so that speeds hover around typical
  // limits. The rest are full 32-bit values that reach saturation.
  function automatic logic [31:0] pick_force();
    logic [31:0] f;
    if ($urandom_range(0, 9) < 7) begin
      f = $urandom_range(0, 32'h0003_FFFF);
      if ($urandom_range(0, 1) == 1) f = -f;
    end else begin
      f = $urandom;
    end
    return f;
  endfunction

  function automatic logic [31:0] pick_start();
    logic [31:0] v;
    if ($urandom_range(0, 1) == 1) begin
      v = $urandom_range(0, 32'h0064_0000);
      if ($urandom_range(0, 1) == 1) v = -v;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Clock and the single reset pulse.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop in case the block hangs or loses a result.
  initial begin
    #(RUN_LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, expected_motion.size());
    $display("Some tests failed");
    $finish;
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result side. It stalls for a random number of cycles before each result,
  // or not at all during the phases without idling. tready stays high across
  // back-to-back results, so that it is never lowered and raised in one step.
  initial begin
    int unsigned stall;
    motion_t     got;
    motion_t     want;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    stall = $urandom_range(0, MAX_IDLE);
    forever begin
      repeat (stall) @(posedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
             m_axis_tdata[127:96], m_axis_tuser};
      if (got.clamped) clamps_seen++;
      if (expected_motion.size() == 0) begin
        $display("%0t: result with no item pending, got %h", $time, got);
        mismatches++;
      end else begin
        want = expected_motion.pop_front();
        compare_field("pos_x", want.pos_x, got.pos_x);
        compare_field("pos_y", want.pos_y, got.pos_y);
        compare_field("vel_x", want.vel_x, got.vel_x);
        compare_field("vel_y", want.vel_y, got.vel_y);
        compare_field("speed_clamped", 32'(want.clamped), 32'(got.clamped));
      end
      stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) m_axis_tready <= 1'b0;
    end
  end

  // Offer one item after a random gap and wait until it is accepted. The task
  // returns at the accepting edge with tvalid still high, so that an item that
  // follows without a gap goes out back to back. It also ends any
  // register-write burst.
  task automatic send_item(input logic [1:0] mode, input logic [31:0] fx,
                           input logic [31:0] fy, input logic typed,
                           input motion_t want);
    int unsigned gap;
    motion_t     model;
    cfg_we_i <= 1'b0;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {fy, fx};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    model = advance_particle(mode, fx, fy);
    expected_motion.push_back(typed ? want : model);
    items_sent++;
    if (mode == MODE_STEP) steps_sent++;
  endtask

  // Stop offering items and wait for every outstanding result. Every item
  // yields a result, so after the last one the block is idle and only the
  // extra cycles that the caller asks for are spent.
  task automatic wait_idle(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    while (expected_motion.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Write one register. Write enable stays high so that a burst of writes goes
  // out on consecutive edges. The next item or the end of the run lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_START_POS_X: home_px = val;
      REG_START_POS_Y: home_py = val;
      REG_START_VEL_X: home_vx = val;
      REG_START_VEL_Y: home_vy = val;
      REG_SPEED_LIMIT: limit   = val[30:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Stimulus.
  initial begin
    bit          prev_item;
    int unsigned counted;
    int unsigned pick;
    logic [31:0] lim_val;
    logic [1:0]  mode;

    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_NONE;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_START_POS_X;
    cfg_data_i    <= '0;
    no_idle       = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    steps_sent    = 0;
    clamps_seen   = 0;
    cfg_writes    = 0;

    // Model state after reset.
    acc_x = '0; acc_y = '0; vel_x = '0; vel_y = '0; pos_x = '0; pos_y = '0;
    home_px = '0; home_py = '0; home_vx = '0; home_vy = '0;
    limit = LIMIT_RESET;

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Directed table. A run of register writes always waits for the block to
    // finish its previous item.
    prev_item = 1'b0;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        if (prev_item) wait_idle(SETTLE_CYCLES);
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
        prev_item = 1'b0;
      end else begin
        send_item(DIRECTED[i].mode, DIRECTED[i].force_x, DIRECTED[i].force_y,
                  DIRECTED[i].typed, DIRECTED[i].want);
        prev_item = 1'b1;
      end
    end

    // Random phases. Each one holds the sender until every result is back,
    // reprograms all registers, and then streams items. The first phases pin
    // the limit to its extremes and to the reset value, and later ones draw it.
    // Every fourth phase runs with no idling on either side.
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle(SETTLE_CYCLES);
      no_idle = (ph % 4 == 3);
      case (ph)
        0: lim_val = Q_MAX;
        1: lim_val = Q_ZERO;
        2: lim_val = 32'(LIMIT_RESET);
        default: lim_val = ($urandom_range(0, 3) == 0) ? $urandom
                                                        : $urandom_range(1, 32'h0028_FFFF);
      endcase
      write_reg(REG_START_POS_X, pick_start());
      write_reg(REG_START_POS_Y, pick_start());
      write_reg(REG_START_VEL_X, pick_start());
      write_reg(REG_START_VEL_Y, pick_start());
      write_reg(REG_SPEED_LIMIT, lim_val);

      // Start from the freshly loaded state in most phases.
      if (ph % 3 != 2) send_item(MODE_RESTART, $urandom, $urandom, 1'b0, '0);

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        // Mostly bursts of forces closed by a step. Restarts, bare steps and
        // unused-mode items make up the noise.
        pick = $urandom_range(0, 99);
        if (pick < 45) mode = MODE_FORCE;
        else if (pick < 80) mode = MODE_STEP;
        else if (pick < 92) mode = MODE_RESTART;
        else mode = MODE_NONE;
        send_item(mode, pick_force(), pick_force(), 1'b0, '0);
        if (mode != MODE_NONE) counted++;
      end
    end

    // Drain: every result back, then a quiet stretch in which no stray result
    // may appear.
    wait_idle(DRAIN_CYCLES);
    cfg_we_i <= 1'b0;

    $display("Sent %0d items (%0d steps), %0d results came back clamped.",
             items_sent, steps_sent, clamps_seen);
    $display("Wrote %0d registers across %0d register settings.",
             cfg_writes, NUM_PHASES + 3);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/pesl_pkg.sv
src/pesl_mul.sv
src/pesl_root_div.sv
src/particle_euler_step_speed_limit.sv
tb/sv/particle_euler_step_speed_limit_tb.sv
